// ----- src/sorted_priority_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Clocked, reset-gated concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared widths, codes and controller/datapath structs of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int DATA_W           = 32;
	localparam int PRIO_W           = 8;
	localparam int STATUS_W         = 2;
	localparam int OCC_W            = 5;
	localparam int DEFAULT_CAPACITY = 16;

	// operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RSVD  = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture a result this cycle
		logic ins;     // insert the incoming entry
		logic rem;     // pop the head entry
		logic full;    // enqueue refused
		logic under;   // dequeue of an empty queue
	} spq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
	} spq_stat_t;

endpackage

`default_nettype wire

// ----- src/spq_if.sv -----
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying queue requests and queue results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_in_if;
	logic                               valid;
	logic                               ready;
	logic                               op;
	logic signed [spq_pkg::DATA_W-1:0]  item_data;
	logic        [spq_pkg::PRIO_W-1:0]  item_priority;

	modport source  (output valid, op, item_data, item_priority, input ready);
	modport sink    (input valid, op, item_data, item_priority, output ready);
	modport monitor (input valid, ready, op, item_data, item_priority);
endinterface

interface spq_out_if;
	logic                                valid;
	logic                                ready;
	logic        [spq_pkg::STATUS_W-1:0] status;
	logic signed [spq_pkg::DATA_W-1:0]   removed_data;
	logic        [spq_pkg::OCC_W-1:0]    occupancy;

	modport source  (output valid, status, removed_data, occupancy, input ready);
	modport sink    (input valid, status, removed_data, occupancy, output ready);
	modport monitor (input valid, ready, status, removed_data, occupancy);
endinterface

`default_nettype wire

// ----- src/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts requests, decodes them against queue status.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	input  spq_pkg::spq_stat_t  stat,
	output spq_pkg::spq_cmd_t   cmd
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_HOLD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// a new request may enter whenever the result slot is free or draining
	assign in_ready  = (state_q == ST_IDLE) || out_ready;
	assign out_valid = (state_q == ST_HOLD);
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd.load  = accept;
		cmd.ins   = accept && (in_op == OP_ENQ) && !stat.full;
		cmd.full  = accept && (in_op == OP_ENQ) &&  stat.full;
		cmd.rem   = accept && (in_op == OP_DEQ) && !stat.empty;
		cmd.under = accept && (in_op == OP_DEQ) &&  stat.empty;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (!accept && out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/spq_dp.sv -----
// ----------------------------------------------------------------------------
// spq_dp
// Sorted shift-register cell array with entry count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_dp #(
	parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  spq_pkg::spq_cmd_t                  cmd,
	input  wire signed [spq_pkg::DATA_W-1:0]   item_data,
	input  wire        [spq_pkg::PRIO_W-1:0]   item_priority,
	output spq_pkg::spq_stat_t                 stat,
	output logic       [spq_pkg::STATUS_W-1:0] status,
	output logic signed [spq_pkg::DATA_W-1:0]  removed_data,
	output logic       [spq_pkg::OCC_W-1:0]    occupancy
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [DATA_W-1:0] val_q [CAPACITY];
	logic [PRIO_W-1:0] pri_q [CAPACITY];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [CAPACITY-1:0] shr;   // cell moves one place toward the tail

	logic [STATUS_W-1:0]      status_q;
	logic [DATA_W-1:0]        removed_q;
	logic [OCC_W-1:0]         occ_q;
	logic [CNT_W+OCC_W-1:0]   occ_wide;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(CAPACITY));

	// occupied cells holding a priority not below the new one
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		assign shr[i] = (count_q > CNT_W'(i)) && (pri_q[i] >= item_priority);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic prev_shr;
		logic [DATA_W-1:0] up_val;
		logic [PRIO_W-1:0] up_pri;
		logic [DATA_W-1:0] dn_val;
		logic [PRIO_W-1:0] dn_pri;

		if (i == 0) begin : g_first
			assign prev_shr = 1'b0;
			assign up_val   = val_q[0];
			assign up_pri   = pri_q[0];
		end else begin : g_rest
			assign prev_shr = shr[i-1];
			assign up_val   = val_q[i-1];
			assign up_pri   = pri_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign dn_val = val_q[i];
			assign dn_pri = pri_q[i];
		end else begin : g_mid
			assign dn_val = val_q[i+1];
			assign dn_pri = pri_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				if (prev_shr) begin
					val_q[i] <= up_val;
					pri_q[i] <= up_pri;
				end else if (shr[i] || (count_q == CNT_W'(i))) begin
					val_q[i] <= item_data;
					pri_q[i] <= item_priority;
				end
			end else if (cmd.rem) begin
				val_q[i] <= dn_val;
				pri_q[i] <= dn_pri;
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.ins)      count_d = count_q + CNT_W'(1);
		else if (cmd.rem) count_d = count_q - CNT_W'(1);
	end

	assign occ_wide = {{OCC_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (cmd.full)       status_q <= STAT_FULL;
			else if (cmd.under) status_q <= STAT_UNDER;
			else                status_q <= STAT_OK;
			removed_q <= cmd.rem ? val_q[0] : '0;
			occ_q     <= occ_wide[OCC_W-1:0];
		end
	end

	assign status       = status_q;
	assign removed_data = removed_q;
	assign occupancy    = occ_q;

endmodule

`default_nettype wire

// ----- src/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of CAPACITY entries kept in ascending priority order.
// ----------------------------------------------------------------------------
// Every request beat on in_ch (enqueue or dequeue) yields exactly one result
// beat on out_ch, in the cycle after acceptance. The entries sit in a row of
// shift-register cells; each cell compares its priority against the incoming
// one in parallel, so an insert or a pop completes at the clock edge
// that accepts the request, and a request can be taken every cycle as long
// as the sink takes results (the one-deep result register is what sets the
// pace under back-pressure). On equal priorities a new entry goes ahead of
// the stored ones. Dequeue of an empty queue returns status underflow with
// zero data; enqueue into a full queue is dropped and returns status full.
// occupancy carries the low five bits of the entry count after the request.
// No clearing pass: cell contents are never read beyond the count, and the
// queue is usable right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
	input  wire      clk,
	input  wire      arst_n,
	spq_in_if.sink   in_ch,
	spq_out_if.source out_ch
);
	import spq_pkg::*;

	spq_cmd_t  cmd;    // controller -> datapath commands
	spq_stat_t stat;   // datapath empty/full flags

	// Controller: handshake on both channels and op decode.
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: sorted cell array, entry count, result register.
	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item_data     (in_ch.item_data),
		.item_priority (in_ch.item_priority),
		.stat          (stat),
		.status        (out_ch.status),
		.removed_data  (out_ch.removed_data),
		.occupancy     (out_ch.occupancy)
	);

endmodule

`default_nettype wire

// ----- src/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the queue's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_checker #(
	parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire        [spq_pkg::STATUS_W-1:0] out_status,
	input wire signed [spq_pkg::DATA_W-1:0]   out_data,
	input wire        [spq_pkg::OCC_W-1:0]    out_occ
);
	import spq_pkg::*;

	// a pending result beat stays until taken
	`SPQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result beat dropped before taken")

	// reserved status code never shows
	`SPQ_ASSERT_SAME(a_status_code, clk, arst_n, out_valid, out_status != STAT_RSVD, "reserved status code on result")

	// underflow only from an empty queue, with no data
	`SPQ_ASSERT_SAME(a_underflow, clk, arst_n, out_valid && (out_status == STAT_UNDER), (out_data == '0) && (out_occ == '0), "underflow with data or entries")

	// full only when every cell holds an entry
	`SPQ_ASSERT_SAME(a_full_occ, clk, arst_n, out_valid && (out_status == STAT_FULL), (out_occ == OCC_W'(CAPACITY)) && (out_data == '0), "full status with free cells")

endmodule

bind sorted_priority_queue spq_checker #(
	.CAPACITY (CAPACITY)
) u_spq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_status (out_ch.status),
	.out_data   (out_ch.removed_data),
	.out_occ    (out_ch.occupancy)
);

`default_nettype wire

// ----- verif/sorted_priority_queue_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives request beats into the queue and checks every result beat against a
// cycle-free predictor of the sorted list: directed corner cases (underflow,
// fill to full, dropped enqueue, equal and extreme priorities, extreme data),
// then randomized phases that push occupancy between empty and full with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_tb;

	import spq_pkg::*;

	localparam int QUEUE_DEPTH  = DEFAULT_CAPACITY;
	localparam int SEGMENT_LEN  = 100;
	localparam int SEGMENTS     = 13;
	localparam int TIMEOUT_TU   = 2000000;

	// one expected result beat
	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] removed_data;
		logic [OCC_W-1:0]         occupancy;
	} queue_result_t;

	// Shadow of the sorted list plus the FIFO of results still owed by the DUT.
	class queue_scoreboard;
		logic signed [DATA_W-1:0] shadow_data[QUEUE_DEPTH];
		logic [PRIO_W-1:0]        shadow_prio[QUEUE_DEPTH];
		int                       held;
		queue_result_t            owed[$];
		int                       errors;

		function new();
			held   = 0;
			errors = 0;
		endfunction

		// accepted request: update the shadow list, queue the expected result
		function void note_request(logic op, logic signed [DATA_W-1:0] data,
			logic [PRIO_W-1:0] prio);
			queue_result_t res;
			int            slot;
			res.status       = STAT_OK;
			res.removed_data = '0;
			if (op == OP_ENQ) begin
				if (held >= QUEUE_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					// first stored entry with priority >= new one; ties put new in front
					slot = held;
					for (int i = 0; i < held; i++) begin
						if (shadow_prio[i] >= prio) begin
							slot = i;
							break;
						end
					end
					for (int i = held; i > slot; i--) begin
						shadow_data[i] = shadow_data[i-1];
						shadow_prio[i] = shadow_prio[i-1];
					end
					shadow_data[slot] = data;
					shadow_prio[slot] = prio;
					held++;
				end
			end else begin
				if (held == 0) begin
					res.status = STAT_UNDER;
				end else begin
					res.removed_data = shadow_data[0];
					for (int i = 1; i < held; i++) begin
						shadow_data[i-1] = shadow_data[i];
						shadow_prio[i-1] = shadow_prio[i];
					end
					held--;
				end
			end
			res.occupancy = held[OCC_W-1:0];
			owed.push_back(res);
		endfunction

		// accepted result: compare against the oldest owed result
		function void check_result(logic [STATUS_W-1:0] status,
			logic signed [DATA_W-1:0] data, logic [OCC_W-1:0] occ);
			queue_result_t want;
			if (owed.size() == 0) begin
				$error("result beat with nothing owed: status %0d data %0d occupancy %0d",
					status, data, occ);
				errors++;
			end else begin
				want = owed.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					errors++;
				end
				if (data !== want.removed_data) begin
					$error("removed_data: expected %0d, actual %0d", want.removed_data, data);
					errors++;
				end
				if (occ !== want.occupancy) begin
					$error("occupancy: expected %0d, actual %0d", want.occupancy, occ);
					errors++;
				end
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spq_in_if  in_ch();
	spq_out_if out_ch();

	queue_scoreboard sb;

	// idle control shared by the sender and the receiver
	bit quiet;          // no idling at all in the closing stretch
	int send_gap_pct;   // chance of an idle burst before a request beat
	int stall_pct;      // chance per cycle of a back-pressure burst

	sorted_priority_queue #(
		.CAPACITY(QUEUE_DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// 4-unit clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// hard stop in case the handshake hangs
	initial begin
		#TIMEOUT_TU;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result monitor: every accepted result beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.status, out_ch.removed_data, out_ch.occupancy);
	end

	// result sink: ready high by default, dropped in random bursts
	initial begin
		out_ch.ready <= 1'b1;
		do @(posedge clk); while (!arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(1, 100) <= stall_pct) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Put one request beat on the channel and hold it until accepted.
	// valid stays high on return so back-to-back beats are sent without a gap.
	task automatic send_request(input logic op, input logic signed [DATA_W-1:0] data,
		input logic [PRIO_W-1:0] prio);
		in_ch.valid         <= 1'b1;
		in_ch.op            <= op;
		in_ch.item_data     <= data;
		in_ch.item_priority <= prio;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(op, data, prio);
	endtask

	// sender idle burst
	task automatic idle_sender(input int cycles);
		in_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// random request; enq_pct biases toward filling, prio_mode shapes priorities
	task automatic send_random(input int enq_pct, input int prio_mode);
		logic              op;
		logic [PRIO_W-1:0] prio;
		op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
		case (prio_mode)
			0: prio = PRIO_W'($urandom_range(0, 3));             // heavy ties
			1: prio = PRIO_W'($urandom_range(0, 255));
			default: prio = $urandom_range(0, 1) ? 8'hFF : PRIO_W'($urandom_range(0, 2));
		endcase
		if (!quiet && $urandom_range(1, 100) <= send_gap_pct)
			idle_sender($urandom_range(1, 19));
		send_request(op, $urandom, prio);
	endtask

	initial begin
		int enq_pct;
		int prio_mode;

		sb           = new();
		quiet        = 1'b0;
		send_gap_pct = 0;
		stall_pct    = 0;

		in_ch.valid         <= 1'b0;
		in_ch.op            <= OP_ENQ;
		in_ch.item_data     <= '0;
		in_ch.item_priority <= '0;
		arst_n              <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, back to back ----
		send_request(OP_DEQ, 32'sh1234_5678, 8'h55);       // underflow on empty
		send_request(OP_ENQ, 32'sh7FFF_FFFF, 8'hFF);       // max data, lowest urgency
		send_request(OP_ENQ, 32'sh8000_0000, 8'h00);       // min data, new head
		send_request(OP_ENQ, 32'sh0000_0001, 8'h00);       // equal to head: goes in front
		send_request(OP_ENQ, 32'shFFFF_FFFF, 8'hFF);       // tie at the tail end
		send_request(OP_ENQ, 32'sh0000_0000, 8'h80);       // lands mid list
		for (int i = 0; i < 11; i++)                       // fill to capacity
			send_request(OP_ENQ, $urandom, PRIO_W'($urandom_range(0, 255)));
		send_request(OP_ENQ, 32'sh5A5A_A5A5, 8'h00);       // full: dropped
		send_request(OP_DEQ, 32'sh0, 8'h00);               // pops the newest prio-0 entry
		send_request(OP_DEQ, 32'shFFFF_FFFF, 8'hFF);
		send_request(OP_DEQ, $urandom, PRIO_W'($urandom_range(0, 255)));
		send_request(OP_DEQ, $urandom, PRIO_W'($urandom_range(0, 255)));

		// ---- random part: phases sweep occupancy and idling ----
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 3)
				0: enq_pct = 85;     // drive toward full, exercise drops
				1: enq_pct = 15;     // drain toward empty, exercise underflow
				default: enq_pct = 50;
			endcase
			prio_mode = $urandom_range(0, 2);
			if (seg == SEGMENTS - 1) begin
				quiet = 1'b1;       // closing stretch at full rate
			end else if (seg % 4 == 2) begin
				send_gap_pct = 0;   // a stretch with no idling
				stall_pct    = 0;
			end else begin
				send_gap_pct = $urandom_range(5, 30);
				stall_pct    = $urandom_range(2, 15);
			end
			for (int k = 0; k < SEGMENT_LEN; k++)
				send_random(enq_pct, prio_mode);
		end
		in_ch.valid <= 1'b0;

		// ---- drain: wait for every owed result before the verdict ----
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
